### rtl/core/pts_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Shared constants, codes and types of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int MaxTasks  = 8;
	localparam int TickWidth = 16;
	localparam int PrioWidth = 8;
	localparam int SlotWidth = $clog2(MaxTasks);
	localparam int CntWidth  = $clog2(MaxTasks + 1);

	localparam logic [TickWidth-1:0] TickForever = {TickWidth{1'b1}};

	typedef enum logic [2:0] {
		OP_CREATE  = 3'd0,
		OP_SLEEP   = 3'd1,
		OP_SUSPEND = 3'd2,
		OP_RESUME  = 3'd3,
		OP_TICK    = 3'd4,
		OP_DISPATCH = 3'd5,
		OP_PREEMPT = 3'd6,
		OP_UNUSED  = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_FULL    = 2'd1,
		STS_IGNORED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SLOT_TERM  = 2'd0,
		SLOT_READY = 2'd1,
		SLOT_WAIT  = 2'd2,
		SLOT_SUSP  = 2'd3
	} slot_state_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DECODE,
		FSM_WALK,
		FSM_INSERT,
		FSM_DONE
	} fsm_t;

	// Controller to datapath
	typedef struct packed {
		logic load;     // capture input beat
		logic decode;   // apply the decode part of the operation
		logic walk;     // one wait-list entry per cycle
		logic insert;   // finish a pending ready-list insertion
		logic publish;  // load the result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_walk;
		logic walk_last;
		logic need_insert;
	} stat_t;

endpackage

### rtl/core/pts_if.sv
// ----------------------------------------------------------------------------
// Scheduler channels
// Valid/ready channels for scheduler operations and results.
// ----------------------------------------------------------------------------
interface pts_op_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [2:0] task_id;
	logic [7:0] priority_req;
	logic [15:0] wait_ticks;
	modport source (output valid, operation, task_id, priority_req, wait_ticks, input ready);
	modport sink (input valid, operation, task_id, priority_req, wait_ticks, output ready);
endinterface

interface pts_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] running_task;
	logic       running_idle;
	logic [2:0] created_slot;
	logic [1:0] status;
	logic [3:0] ready_count;
	logic [3:0] woken_count;
	modport source (output valid, running_task, running_idle, created_slot, status,
		ready_count, woken_count, input ready);
	modport sink (input valid, running_task, running_idle, created_slot, status,
		ready_count, woken_count, output ready);
endinterface

### rtl/core/priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// Priority task scheduler
// Top level: controller, datapath and the enable register.
// ----------------------------------------------------------------------------
// One operation beat is taken at a time. An operation passes through capture,
// decode and result load, with a wait-list walk in between on a tick, one entry
// per cycle, or an insertion step when a created, resumed or preempted task
// joins the ready list. The result load waits while the previous result is
// still unaccepted. A finished result waits in an output register; the next
// operation is taken only once that register has been loaded.
// Write scheduler_enabled only while no operation is in flight.
module priority_task_scheduler (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  logic   cfg_wdata,
	pts_op_if.sink     op_in,
	pts_res_if.source  res
);

	logic            enabled_q;
	pts_pkg::cmd_t   cmd;
	pts_pkg::stat_t  stat;
	logic            rdy;

	// hold the enable bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg_we) begin
			enabled_q <= cfg_wdata;
		end
	end

	pts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (op_in.valid),
		.in_ready (rdy),
		.res_busy (res.valid && !res.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// take a new operation only while the controller is idle
	assign op_in.ready = rdy;

	pts_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.scheduler_enabled (enabled_q),
		.cmd               (cmd),
		.stat              (stat),
		.op_in             (op_in),
		.res               (res)
	);

endmodule

### rtl/core/pts_ctrl.sv
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences one operation through capture, decode, wait-list walk or insertion, and result load.
// ----------------------------------------------------------------------------
module pts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           res_busy,
	input  pts_pkg::stat_t stat,
	output pts_pkg::cmd_t  cmd
);

	pts_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pts_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pts_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = pts_pkg::FSM_DECODE;
				end
			end
			pts_pkg::FSM_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.need_walk) begin
					state_d = pts_pkg::FSM_WALK;
				end else if (stat.need_insert) begin
					state_d = pts_pkg::FSM_INSERT;
				end else begin
					state_d = pts_pkg::FSM_DONE;
				end
			end
			pts_pkg::FSM_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_last) begin
					state_d = pts_pkg::FSM_DONE;
				end
			end
			pts_pkg::FSM_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = pts_pkg::FSM_DONE;
			end
			pts_pkg::FSM_DONE: begin
				// hold until the result register is free
				if (!res_busy) begin
					cmd.publish = 1'b1;
					state_d     = pts_pkg::FSM_IDLE;
				end
			end
			default: state_d = pts_pkg::FSM_IDLE;
		endcase
	end

endmodule

### rtl/core/pts_dp.sv
// ----------------------------------------------------------------------------
// Scheduler datapath
// Task table, ready and wait lists, and the result register.
// ----------------------------------------------------------------------------
module pts_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           scheduler_enabled,
	input  pts_pkg::cmd_t  cmd,
	output pts_pkg::stat_t stat,
	pts_op_if.sink         op_in,
	pts_res_if.source      res
);

	localparam int N  = pts_pkg::MaxTasks;
	localparam int SW = pts_pkg::SlotWidth;
	localparam int CW = pts_pkg::CntWidth;
	localparam int TW = pts_pkg::TickWidth;
	localparam int PW = pts_pkg::PrioWidth;

	typedef logic [SW-1:0] slot_t;
	typedef logic [CW-1:0] cnt_t;

	// captured operation
	pts_pkg::op_t    op_q;
	slot_t           tid_q;
	logic [PW-1:0]   prio_q;
	logic [TW-1:0]   wt_q;

	logic [PW-1:0]   prio_q_arr [N];
	pts_pkg::slot_state_t sstat_q [N];
	logic [TW-1:0]   cd_q [N];
	slot_t           rdy_q [N];
	cnt_t            rlen_q;
	slot_t           wl_q [N];
	cnt_t            wlen_q;
	cnt_t            used_q;
	slot_t           cur_q;
	logic            idle_q;

	// walk state
	cnt_t            widx_q;
	cnt_t            woken_q;
	slot_t           created_q;
	pts_pkg::status_t sts_q;
	slot_t           pslot_q;

	logic            res_valid_q;

	// ---------------------------------------------------------------- helpers
	// ordered insert of one slot into the ready list
	function automatic void rdy_ins(input slot_t s, input slot_t l_in [N],
		input cnt_t n_in, input logic [PW-1:0] pa [N],
		output slot_t l_out [N], output cnt_t n_out);
		logic hit;
		logic found;
		cnt_t pos;
		l_out = l_in;
		n_out = n_in;
		hit   = 1'b0;
		found = 1'b0;
		pos   = n_in;
		for (int i = 0; i < N; i++) begin
			if (cnt_t'(i) < n_in && l_in[i] == s) hit = 1'b1;
			if (!found && cnt_t'(i) < n_in && pa[s] > pa[l_in[i]]) begin
				found = 1'b1;
				pos   = cnt_t'(i);
			end
		end
		if (n_in < cnt_t'(N) && !hit) begin
			for (int i = 1; i < N; i++) begin
				if (cnt_t'(i) > pos && cnt_t'(i) <= n_in) l_out[i] = l_in[i-1];
			end
			l_out[pos[SW-1:0]] = s;
			n_out = n_in + cnt_t'(1);
		end
	endfunction

	function automatic void lst_rm(input slot_t s, input slot_t l_in [N],
		input cnt_t n_in, output slot_t l_out [N], output cnt_t n_out);
		logic found;
		l_out = l_in;
		n_out = n_in;
		found = 1'b0;
		for (int i = 0; i < N; i++) begin
			if (cnt_t'(i) < n_in && l_in[i] == s) found = 1'b1;
			if (found && i + 1 < N) l_out[i] = l_in[i+1];
		end
		if (found) n_out = n_in - cnt_t'(1);
	endfunction

	function automatic void lst_pop(input cnt_t at, input slot_t l_in [N],
		input cnt_t n_in, output slot_t l_out [N], output cnt_t n_out);
		l_out = l_in;
		n_out = n_in;
		for (int i = 0; i < N - 1; i++) begin
			if (cnt_t'(i) >= at) l_out[i] = l_in[i+1];
		end
		if (at < n_in) n_out = n_in - cnt_t'(1);
	endfunction

	// wait list ordered by priority, same rule as ready list
	function automatic void wl_ins(input slot_t s, input slot_t l_in [N],
		input cnt_t n_in, input logic [PW-1:0] pa [N],
		output slot_t l_out [N], output cnt_t n_out);
		rdy_ins(s, l_in, n_in, pa, l_out, n_out);
	endfunction

	// ------------------------------------------------------------ decode step
	slot_t            rm_l [N];
	cnt_t             rm_n;
	slot_t            head_s;
	logic             head_ok;
	logic             take_head;
	slot_t            rdy_d [N];
	cnt_t             rlen_d;
	slot_t            wl_d [N];
	cnt_t             wlen_d;
	logic             dec_pend;
	slot_t            dec_pslot;
	pts_pkg::status_t dec_sts;
	logic             dec_rm_rdy;
	logic             dec_sleep;
	logic             dec_dispatch;
	logic             dec_preempt;
	logic             slot_ok;

	slot_t            ws;
	logic [TW-1:0]    wcd;
	logic             wexp;
	logic             wlast;
	slot_t            wl_rm_l [N];
	cnt_t             wl_rm_n;
	slot_t            rw_l [N];
	cnt_t             rw_n;
	slot_t            ins_l [N];
	cnt_t             ins_n;

	always_comb begin
		slot_ok      = cnt_t'(tid_q) < used_q;
		dec_sts      = pts_pkg::STS_OK;
		dec_pend     = 1'b0;
		dec_pslot    = tid_q;
		dec_rm_rdy   = 1'b0;
		dec_sleep    = 1'b0;
		dec_dispatch = 1'b0;
		dec_preempt  = 1'b0;
		unique case (op_q)
			pts_pkg::OP_CREATE: begin
				if (used_q >= cnt_t'(N)) dec_sts = pts_pkg::STS_FULL;
				else begin
					dec_pend  = 1'b1;
					dec_pslot = used_q[SW-1:0];
				end
			end
			pts_pkg::OP_SLEEP: begin
				if (wt_q == '0 || idle_q) dec_sts = pts_pkg::STS_IGNORED;
				else begin
					dec_sleep    = 1'b1;
					dec_dispatch = scheduler_enabled;
				end
			end
			pts_pkg::OP_SUSPEND: begin
				if (!slot_ok) dec_sts = pts_pkg::STS_IGNORED;
				else dec_rm_rdy = 1'b1;
			end
			pts_pkg::OP_RESUME: begin
				if (!slot_ok) dec_sts = pts_pkg::STS_IGNORED;
				else dec_pend = idle_q || tid_q != cur_q;
			end
			pts_pkg::OP_TICK: ;
			pts_pkg::OP_DISPATCH: dec_dispatch = 1'b1;
			pts_pkg::OP_PREEMPT: begin
				dec_preempt = rlen_q != '0 &&
					(idle_q || prio_q_arr[rdy_q[0]] >= prio_q_arr[cur_q]);
				dec_pend  = dec_preempt && !idle_q;
				dec_pslot = cur_q;
			end
			pts_pkg::OP_UNUSED: dec_sts = pts_pkg::STS_IGNORED;
			default: dec_sts = pts_pkg::STS_IGNORED;
		endcase

		// drop the sleeper or the suspended task from the ready list
		rm_l = rdy_q;
		rm_n = rlen_q;
		if (dec_sleep || dec_rm_rdy) begin
			lst_rm(dec_sleep ? cur_q : tid_q, rdy_q, rlen_q, rm_l, rm_n);
		end
		// head after that removal runs on dispatch or preempt
		head_s    = rm_l[0];
		head_ok   = rm_n != '0;
		take_head = (dec_dispatch || dec_preempt) && head_ok;
		rdy_d  = rm_l;
		rlen_d = rm_n;
		if (take_head) lst_pop('0, rm_l, rm_n, rdy_d, rlen_d);
		wl_d   = wl_q;
		wlen_d = wlen_q;
		if (dec_sleep) wl_ins(cur_q, wl_q, wlen_q, prio_q_arr, wl_d, wlen_d);
	end

	// walk step and pending insertion
	always_comb begin
		ws    = wl_q[widx_q[SW-1:0]];
		wcd   = cd_q[ws];
		if (wcd != pts_pkg::TickForever && wcd != '0) wcd = wcd - TW'(1);
		wexp  = cd_q[ws] != pts_pkg::TickForever && wcd == '0;
		wlast = wexp ? (widx_q + cnt_t'(1) >= wlen_q) : (widx_q + cnt_t'(2) > wlen_q);
		lst_pop(widx_q, wl_q, wlen_q, wl_rm_l, wl_rm_n);
		rdy_ins(ws, rdy_q, rlen_q, prio_q_arr, rw_l, rw_n);
		rdy_ins(pslot_q, rdy_q, rlen_q, prio_q_arr, ins_l, ins_n);
	end

	assign stat.need_walk   = op_q == pts_pkg::OP_TICK && wlen_q != '0;
	assign stat.walk_last   = wlast;
	assign stat.need_insert = dec_pend;

	// ------------------------------------------------------------- registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= pts_pkg::OP_TICK;
			tid_q  <= '0;
			prio_q <= '0;
			wt_q   <= '0;
		end else if (cmd.load) begin
			op_q   <= pts_pkg::op_t'(op_in.operation);
			tid_q  <= slot_t'(op_in.task_id);
			prio_q <= PW'(op_in.priority_req);
			wt_q   <= TW'(op_in.wait_ticks);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				sstat_q[i] <= pts_pkg::SLOT_TERM;
				cd_q[i]    <= pts_pkg::TickForever;
			end
			rlen_q    <= '0;
			wlen_q    <= '0;
			used_q    <= '0;
			cur_q     <= '0;
			idle_q    <= 1'b1;
			widx_q    <= '0;
			woken_q   <= '0;
			created_q <= '0;
			sts_q     <= pts_pkg::STS_OK;
			pslot_q   <= '0;
		end else begin
			if (cmd.decode) begin
				widx_q    <= '0;
				woken_q   <= '0;
				sts_q     <= dec_sts;
				pslot_q   <= dec_pslot;
				rlen_q    <= rlen_d;
				wlen_q    <= wlen_d;
				created_q <= (op_q == pts_pkg::OP_CREATE && dec_pend) ? dec_pslot : '0;
				if (op_q == pts_pkg::OP_CREATE && dec_pend) begin
					used_q             <= used_q + cnt_t'(1);
					sstat_q[dec_pslot] <= pts_pkg::SLOT_READY;
					cd_q[dec_pslot]    <= pts_pkg::TickForever;
				end
				if (dec_sleep) begin
					sstat_q[cur_q] <= pts_pkg::SLOT_WAIT;
					cd_q[cur_q]    <= wt_q;
				end
				if (op_q == pts_pkg::OP_SUSPEND && slot_ok) sstat_q[tid_q] <= pts_pkg::SLOT_SUSP;
				if (op_q == pts_pkg::OP_RESUME && slot_ok) sstat_q[tid_q] <= pts_pkg::SLOT_READY;
				if (take_head) begin
					cur_q  <= head_s;
					idle_q <= 1'b0;
				end else if (dec_dispatch) begin
					// empty ready list: fall back to the idle task
					idle_q <= 1'b1;
				end
			end
			if (cmd.walk) begin
				if (cd_q[ws] != pts_pkg::TickForever) cd_q[ws] <= wcd;
				if (wexp) begin
					sstat_q[ws] <= pts_pkg::SLOT_READY;
					wlen_q      <= wl_rm_n;
					rlen_q      <= rw_n;
					woken_q     <= woken_q + cnt_t'(1);
				end else begin
					widx_q <= widx_q + cnt_t'(1);
				end
			end
			if (cmd.insert) begin
				rlen_q <= ins_n;
			end
		end
	end

	// payload arrays: priority table, list contents
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			rdy_q <= rdy_d;
			wl_q  <= wl_d;
			if (op_q == pts_pkg::OP_CREATE && dec_pend) prio_q_arr[dec_pslot] <= prio_q;
		end
		if (cmd.walk && wexp) begin
			wl_q  <= wl_rm_l;
			rdy_q <= rw_l;
		end
		if (cmd.insert) rdy_q <= ins_l;
	end

	// ---------------------------------------------------------- result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			res.running_task <= idle_q ? 3'd0 : 3'(cur_q);
			res.running_idle <= idle_q;
			res.created_slot <= 3'(created_q);
			res.status       <= sts_q;
			res.ready_count  <= 4'(rlen_q);
			res.woken_count  <= 4'(woken_q);
		end
	end

	assign res.valid = res_valid_q;

endmodule
